@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the brightness ramp packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ rtl/pbrp_pkg.sv @@
// Package with shared types, constants and helper functions of the ramp packer.
package pbrp_pkg;

    localparam int COMP_BITS          = 8;
    localparam int PIXEL_BITS         = 16;
    localparam int NUM_CH             = 3;
    localparam int LEVEL_BITS_DEFAULT = 6;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 16;
    localparam int POS_BITS           = 4;
    localparam int DROP_BITS          = 4;
    localparam int DIV_BITS           = COMP_BITS + 1;
    localparam int RECIP_SHIFT        = 2 * COMP_BITS + 1;
    localparam int RECIP_BITS         = RECIP_SHIFT + 1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam logic [CFG_DATA_BITS-1:0] RED_MASK_RESET   = 16'hF800;
    localparam logic [CFG_DATA_BITS-1:0] GREEN_MASK_RESET = 16'h07E0;
    localparam logic [CFG_DATA_BITS-1:0] BLUE_MASK_RESET  = 16'h001F;

    typedef struct packed {
        logic [POS_BITS-1:0]  pos;
        logic [DROP_BITS-1:0] drop;
    } field_t;

    typedef field_t [NUM_CH-1:0] field_set_t;

    typedef struct packed {
        logic [NUM_CH-1:0][COMP_BITS-1:0] quo;
        logic [NUM_CH-1:0][COMP_BITS-1:0] rem;
        logic                             final_color;
    } ramp_entry_t;

    typedef struct packed {
        logic [COMP_BITS-1:0] quo;
        logic [COMP_BITS-1:0] rem;
    } divmod_t;

    // Position of the lowest set bit, and COMP_BITS minus the width of the lowest run of ones (at most COMP_BITS).
    function automatic field_t analyze_mask(input logic [CFG_DATA_BITS-1:0] mask);
        field_t                   f;
        logic [POS_BITS-1:0]      pos;
        logic [CFG_DATA_BITS-1:0] shifted;
        logic [DROP_BITS-1:0]     width;
        logic                     run;
        pos = '0;
        for (int i = CFG_DATA_BITS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                pos = POS_BITS'(i);
            end
        end
        shifted = mask >> pos;
        width   = '0;
        run     = 1'b1;
        for (int i = 0; i < COMP_BITS; i++) begin
            run = run & shifted[i];
            if (run) begin
                width = DROP_BITS'(i + 1);
            end
        end
        f.pos  = pos;
        f.drop = DROP_BITS'(COMP_BITS) - width;
        return f;
    endfunction

    // Quotient and remainder of one component by the level divisor, taken from
    // the product with the rounded-up reciprocal of the divisor.
    function automatic divmod_t div_component(input logic [COMP_BITS-1:0]  comp,
                                              input logic [DIV_BITS-1:0]   divisor,
                                              input logic [RECIP_BITS-1:0] recip);
        divmod_t                         res;
        logic [COMP_BITS+RECIP_BITS-1:0] prod;
        logic [COMP_BITS+DIV_BITS-1:0]   mult_back;
        logic [COMP_BITS-1:0]            quo;
        prod      = {{RECIP_BITS{1'b0}}, comp} * {{COMP_BITS{1'b0}}, recip};
        quo       = prod[RECIP_SHIFT +: COMP_BITS];
        mult_back = {{DIV_BITS{1'b0}}, quo} * {{COMP_BITS{1'b0}}, divisor};
        res.quo   = quo;
        res.rem   = comp - mult_back[COMP_BITS-1:0];
        return res;
    endfunction

endpackage

@@ rtl/palette_brightness_ramp_packer.sv @@
// Top level of the palette brightness ramp packer.
// Path: front stage register, two-entry queue, ramp generator state, registered output pixel.
// Throughput: one pixel per cycle unless m_tready holds the output, giving 2**LEVEL_BITS
// pixels per color (64 by default); the ramp generator emits one level per cycle.
// Reset: synchronous, active low; the masks return to 0xF800, 0x07E0 and 0x001F.
`include "assert_macros.svh"

module palette_brightness_ramp_packer
    import pbrp_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [NUM_CH*COMP_BITS-1:0] s_tdata,
    // final_color
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // packed_pixel [15:0], level [15+LEVEL_BITS:16], zero padding above
    output logic [((PIXEL_BITS + LEVEL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // run_last
    output logic                        m_tlast,
    // table_end
    output logic                        m_tuser
);

    localparam int OUT_BITS = ((PIXEL_BITS + LEVEL_BITS + 7) / 8) * 8;

    field_set_t            fields;
    logic                  fr_valid;
    logic                  fr_ready;
    ramp_entry_t           fr_data;
    logic                  bk_valid;
    logic                  bk_ready;
    ramp_entry_t           bk_data;
    logic [PIXEL_BITS-1:0] pixel;
    logic [LEVEL_BITS-1:0] level;

    pbrp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fields    (fields)
    );

    pbrp_front #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .ent_valid (fr_valid),
        .ent_ready (fr_ready),
        .ent_data  (fr_data)
    );

    pbrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    pbrp_back #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fields        (fields),
        .ent_valid     (bk_valid),
        .ent_ready     (bk_ready),
        .ent_data      (bk_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_pixel     (pixel),
        .out_level     (level),
        .out_run_last  (m_tlast),
        .out_table_end (m_tuser)
    );

    assign m_tdata = OUT_BITS'({level, pixel});

    `ASSERT_CLK(a_last_on_top_level, aclk, aresetn, (m_tvalid && m_tlast) |-> (level == '1))
    `ASSERT_NEVER(a_end_needs_last, aclk, aresetn, m_tvalid && m_tuser && !m_tlast)
    `ASSERT_CLK(a_ramp_no_bubble, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)

endmodule

@@ rtl/pbrp_cfg.sv @@
// Field mask registers, stored as decoded field position and shift amount.
module pbrp_cfg
    import pbrp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wen,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output field_set_t                fields
);

    field_set_t fields_reg;
    field_set_t fields_next;
    field_t     decoded;

    always_comb begin
        decoded     = analyze_mask(cfg_wdata);
        fields_next = fields_reg;
        if (cfg_wen) begin
            unique case (cfg_index_t'(cfg_index))
                REG_RED_MASK:   fields_next[CH_RED]   = decoded;
                REG_GREEN_MASK: fields_next[CH_GREEN] = decoded;
                REG_BLUE_MASK:  fields_next[CH_BLUE]  = decoded;
                default:        fields_next = fields_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fields_reg[CH_RED]   <= analyze_mask(RED_MASK_RESET);
            fields_reg[CH_GREEN] <= analyze_mask(GREEN_MASK_RESET);
            fields_reg[CH_BLUE]  <= analyze_mask(BLUE_MASK_RESET);
        end else begin
            fields_reg <= fields_next;
        end
    end

    assign fields = fields_reg;

endmodule

@@ rtl/pbrp_front.sv @@
// Front stage: accepts a color and splits each component by the level divisor.
module pbrp_front
    import pbrp_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [NUM_CH*COMP_BITS-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        ent_valid,
    input  logic                        ent_ready,
    output ramp_entry_t                 ent_data
);

    localparam logic [DIV_BITS-1:0] DIVISOR = DIV_BITS'((1 << LEVEL_BITS) - 1);
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((1 << RECIP_SHIFT) + (1 << LEVEL_BITS) - 2) / ((1 << LEVEL_BITS) - 1));

    logic        valid_reg;
    logic        valid_next;
    ramp_entry_t entry_reg;
    ramp_entry_t entry_next;
    logic        accept;
    divmod_t     dm [NUM_CH];

    assign s_tready = !valid_reg || ent_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        entry_next = entry_reg;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            dm[ch] = div_component(s_tdata[ch*COMP_BITS +: COMP_BITS], DIVISOR, RECIP);
            entry_next.quo[ch] = dm[ch].quo;
            entry_next.rem[ch] = dm[ch].rem;
        end
        entry_next.final_color = s_tlast;
        priority if (accept) begin
            valid_next = 1'b1;
        end else if (ent_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            entry_reg <= entry_next;
        end
    end

    assign ent_valid = valid_reg;
    assign ent_data  = entry_reg;

endmodule

@@ rtl/pbrp_queue.sv @@
// Two-entry queue between the front stage and the ramp generator.
module pbrp_queue
    import pbrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  ramp_entry_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ramp_entry_t out_data
);

    localparam int DEPTH = 2;

    ramp_entry_t slot_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_ready  = count_reg != 2'(DEPTH);
    assign out_valid = count_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/pbrp_back.sv @@
// Ramp generator: steps through all levels of a color and packs each pixel.
module pbrp_back
    import pbrp_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  field_set_t            fields,
    input  logic                  ent_valid,
    output logic                  ent_ready,
    input  ramp_entry_t           ent_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_BITS-1:0] out_pixel,
    output logic [LEVEL_BITS-1:0] out_level,
    output logic                  out_run_last,
    output logic                  out_table_end
);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

    logic                                active_reg;
    logic                                active_next;
    logic [LEVEL_BITS-1:0]               level_reg;
    logic [LEVEL_BITS-1:0]               level_next;
    logic [NUM_CH-1:0][COMP_BITS-1:0]    q_reg;
    logic [NUM_CH-1:0][COMP_BITS-1:0]    q_next;
    logic [NUM_CH-1:0][LEVEL_BITS-1:0]   r_reg;
    logic [NUM_CH-1:0][LEVEL_BITS-1:0]   r_next;
    logic [NUM_CH-1:0][COMP_BITS-1:0]    qc_reg;
    logic [NUM_CH-1:0][COMP_BITS-1:0]    qc_next;
    logic [NUM_CH-1:0][LEVEL_BITS-1:0]   rc_reg;
    logic [NUM_CH-1:0][LEVEL_BITS-1:0]   rc_next;
    logic                                final_reg;
    logic                                final_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [PIXEL_BITS-1:0]               pixel_reg;
    logic [LEVEL_BITS-1:0]               out_level_reg;
    logic                                run_last_reg;
    logic                                table_end_reg;
    logic                                emit;
    logic                                at_last;
    logic                                pop;
    logic [PIXEL_BITS-1:0]               pixel;
    logic [PIXEL_BITS-1:0]               part;
    logic [LEVEL_BITS:0]                 r_sum;
    logic                                carry;

    assign emit      = active_reg && (!out_valid_reg || out_ready);
    assign at_last   = level_reg == LEVEL_MAX;
    assign ent_ready = !active_reg || (emit && at_last);
    assign pop       = ent_valid && ent_ready;

    always_comb begin
        pixel = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            part  = PIXEL_BITS'(q_reg[ch] >> fields[ch].drop);
            pixel = pixel | (part << fields[ch].pos);
        end
    end

    always_comb begin
        active_next = active_reg;
        level_next  = level_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        qc_next     = qc_reg;
        rc_next     = rc_reg;
        final_next  = final_reg;
        r_sum       = '0;
        carry       = 1'b0;
        priority if (pop) begin
            active_next = 1'b1;
            level_next  = '0;
            q_next      = '0;
            r_next      = '0;
            final_next  = ent_data.final_color;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                qc_next[ch] = ent_data.quo[ch];
                rc_next[ch] = ent_data.rem[ch][LEVEL_BITS-1:0];
            end
        end else if (emit) begin
            active_next = !at_last;
            level_next  = level_reg + LEVEL_BITS'(1);
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_sum = {1'b0, r_reg[ch]} + {1'b0, rc_reg[ch]};
                carry = r_sum >= {1'b0, LEVEL_MAX};
                if (carry) begin
                    r_sum = r_sum - {1'b0, LEVEL_MAX};
                end
                r_next[ch] = r_sum[LEVEL_BITS-1:0];
                q_next[ch] = q_reg[ch] + qc_reg[ch] + COMP_BITS'(carry);
            end
        end else begin
            active_next = active_reg;
        end
        priority if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
        level_reg <= level_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        qc_reg    <= qc_next;
        rc_reg    <= rc_next;
        final_reg <= final_next;
        if (emit) begin
            pixel_reg     <= pixel;
            out_level_reg <= level_reg;
            run_last_reg  <= at_last;
            table_end_reg <= at_last && final_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pixel     = pixel_reg;
    assign out_level     = out_level_reg;
    assign out_run_last  = run_last_reg;
    assign out_table_end = table_end_reg;

endmodule

@@ sim/palette_brightness_ramp_packer_test.sv @@
// Self-checking testbench for the palette brightness ramp packer.
module palette_brightness_ramp_packer_test
    import pbrp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVEL_COUNT = 1 << LEVEL_BITS_DEFAULT;
    localparam int MAX_LEVEL = LEVEL_COUNT - 1;
    localparam int OUT_BITS = ((PIXEL_BITS + LEVEL_BITS_DEFAULT + 7) / 8) * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int COLORS_PER_PHASE = 42;

    typedef struct {
        logic [COMP_BITS-1:0] red;
        logic [COMP_BITS-1:0] green;
        logic [COMP_BITS-1:0] blue;
        logic                 last;
    } palette_color_t;

    typedef struct {
        logic [PIXEL_BITS-1:0]         pixel;
        logic [LEVEL_BITS_DEFAULT-1:0] level;
        logic                          run_last;
        logic                          table_end;
    } ramp_pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_RED_MASK;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [NUM_CH*COMP_BITS-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    logic [CFG_DATA_BITS-1:0] red_mask = RED_MASK_RESET;
    logic [CFG_DATA_BITS-1:0] green_mask = GREEN_MASK_RESET;
    logic [CFG_DATA_BITS-1:0] blue_mask = BLUE_MASK_RESET;

    palette_color_t color_q[$];
    ramp_pixel_t pixel_ramp_q[$];
    palette_color_t presented_color;
    int colors_queued = 0;
    int colors_taken = 0;
    int send_gap = 0;
    int sink_gap = 0;
    int fault_count = 0;
    int stall_cycles = 0;
    bit steady_flow = 1'b0;

    palette_brightness_ramp_packer dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scales one channel to a brightness level and moves it to its field in the pixel.
    function automatic logic [PIXEL_BITS-1:0] scale_channel(input logic [COMP_BITS-1:0] comp,
                                                            input int lvl,
                                                            input logic [CFG_DATA_BITS-1:0] mask);
        int pos;
        int width;
        int scaled;
        pos = 0;
        width = 0;
        if (mask != '0) begin
            while (!mask[pos]) pos++;
            while (pos + width < CFG_DATA_BITS && mask[pos + width]) width++;
        end
        if (width > COMP_BITS) width = COMP_BITS;
        if (width == 0) return '0;
        scaled = (int'(comp) * lvl) / MAX_LEVEL;
        return PIXEL_BITS'((scaled >> (COMP_BITS - width)) << pos);
    endfunction

    task automatic predict_ramp(input palette_color_t c);
        ramp_pixel_t p;
        for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
            p.pixel = scale_channel(c.red, lvl, red_mask) | scale_channel(c.green, lvl, green_mask)
                    | scale_channel(c.blue, lvl, blue_mask);
            p.level = LEVEL_BITS_DEFAULT'(lvl);
            p.run_last = (lvl == MAX_LEVEL);
            p.table_end = (lvl == MAX_LEVEL) && c.last;
            pixel_ramp_q.push_back(p);
        end
    endtask

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 50) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_ramp(presented_color);
                colors_taken++;
                send_gap = pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (color_q.size() > 0) begin
                    presented_color = color_q.pop_front();
                    s_tdata <= {presented_color.blue, presented_color.green, presented_color.red};
                    s_tlast <= presented_color.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_fault(input string what, input ramp_pixel_t want, input ramp_pixel_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%s: expected pixel %h level %0d last %b end %b,", what,
                     want.pixel, want.level, want.run_last, want.table_end);
            $display("    got pixel %h level %0d last %b end %b",
                     got.pixel, got.level, got.run_last, got.table_end);
        end
    endtask

    always @(posedge aclk) begin
        ramp_pixel_t got;
        ramp_pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pixel = m_tdata[PIXEL_BITS-1:0];
                got.level = m_tdata[PIXEL_BITS +: LEVEL_BITS_DEFAULT];
                got.run_last = m_tlast;
                got.table_end = m_tuser;
                if (pixel_ramp_q.size() == 0) begin
                    want = '{default: '0};
                    note_fault("unexpected pixel", want, got);
                end else begin
                    want = pixel_ramp_q.pop_front();
                    if (got.pixel !== want.pixel || got.level !== want.level
                            || got.run_last !== want.run_last
                            || got.table_end !== want.table_end) begin
                        note_fault("pixel mismatch", want, got);
                    end
                end
                sink_gap = pick_gap();
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic last);
        palette_color_t c;
        c.red = r;
        c.green = g;
        c.blue = b;
        c.last = last;
        color_q.push_back(c);
        colors_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (colors_taken != colors_queued || pixel_ramp_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three masks, optionally followed by a write to the unused index.
    task automatic program_masks(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                                 input bit stray_write);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= REG_RED_MASK;
        cfg_wdata <= r;
        red_mask = r;
        @(posedge aclk);
        cfg_index <= REG_GREEN_MASK;
        cfg_wdata <= g;
        green_mask = g;
        @(posedge aclk);
        cfg_index <= REG_BLUE_MASK;
        cfg_wdata <= b;
        blue_mask = b;
        if (stray_write) begin
            @(posedge aclk);
            cfg_index <= REG_UNUSED;
            cfg_wdata <= 16'($urandom);
        end
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] random_mask();
        int unsigned roll;
        int pos;
        int width;
        roll = $urandom_range(99);
        if (roll < 15) begin
            case ($urandom_range(3))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return 16'h0001;
                default: return 16'h8000;
            endcase
        end
        if (roll < 60) begin
            pos = $urandom_range(15);
            width = $urandom_range(10, 1);
            return 16'(((32'h1 << width) - 1) << pos);
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] random_channel();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        queue_color(8'h00, 8'h00, 8'h00, 1'b0);
        queue_color(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_color(8'hFF, 8'h00, 8'h00, 1'b0);
        queue_color(8'h00, 8'hFF, 8'h00, 1'b0);
        queue_color(8'h00, 8'h00, 8'hFF, 1'b1);
        queue_color(8'h01, 8'h01, 8'h01, 1'b0);
        queue_color(8'h80, 8'h40, 8'h20, 1'b1);
        queue_color(8'hAA, 8'h55, 8'hAA, 1'b1);
        wait_drained();

        program_masks(16'h0000, 16'h0000, 16'h0000, 1'b1);
        queue_color(8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_color(8'h12, 8'h34, 8'h56, 1'b0);
        wait_drained();

        program_masks(16'hFFFF, 16'h8000, 16'h0001, 1'b0);
        queue_color(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_color(8'h55, 8'hAA, 8'h0F, 1'b1);
        queue_color(8'hFE, 8'h7F, 8'h81, 1'b0);
        wait_drained();

        program_masks(16'hF0F1, 16'h0F3C, 16'h00FC, 1'b1);
        queue_color(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_color(8'hC3, 8'h3C, 8'h99, 1'b0);
        queue_color(8'h7F, 8'h80, 8'h01, 1'b1);
        wait_drained();

        program_masks(16'hFF00, 16'h00FF, 16'hFFF0, 1'b0);
        queue_color(8'hFF, 8'h80, 8'h7F, 1'b1);
        queue_color(8'h00, 8'hFF, 8'hFF, 1'b0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                program_masks(RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET, 1'b0);
            end else begin
                program_masks(random_mask(), random_mask(), random_mask(), $urandom_range(1));
            end
            steady_flow = (phase % 3 == 2);
            for (int n = 0; n < COLORS_PER_PHASE; n++) begin
                queue_color(random_channel(), random_channel(), random_channel(),
                            $urandom_range(7) == 0);
            end
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (pixel_ramp_q.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pbrp_pkg.sv
rtl/pbrp_cfg.sv
rtl/pbrp_front.sv
rtl/pbrp_queue.sv
rtl/pbrp_back.sv
rtl/palette_brightness_ramp_packer.sv
sim/palette_brightness_ramp_packer_test.sv
